/* sv/sm83_alu_pkg.sv */
package sm83_alu_pkg;

  typedef enum logic [5:0] {
    OP_ADD    = 6'd0,
    OP_ADC    = 6'd1,
    OP_SUB    = 6'd2,
    OP_SBC    = 6'd3,
    OP_AND    = 6'd4,
    OP_XOR    = 6'd5,
    OP_OR     = 6'd6,
    OP_CP     = 6'd7,
    OP_INC8   = 6'd8,
    OP_DEC8   = 6'd9,
    OP_DAA    = 6'd10,
    OP_CPL    = 6'd11,
    OP_SCF    = 6'd12,
    OP_CCF    = 6'd13,
    OP_RLCA   = 6'd14,
    OP_RRCA   = 6'd15,
    OP_RLA    = 6'd16,
    OP_RRA    = 6'd17,
    OP_RLC    = 6'd18,
    OP_RRC    = 6'd19,
    OP_RL     = 6'd20,
    OP_RR     = 6'd21,
    OP_SLA    = 6'd22,
    OP_SRA    = 6'd23,
    OP_SRL    = 6'd24,
    OP_SWAP   = 6'd25,
    OP_BIT    = 6'd26,
    OP_RES    = 6'd27,
    OP_SET    = 6'd28,
    OP_ADDW   = 6'd29,
    OP_SPE8   = 6'd30,
    OP_INCW   = 6'd31,
    OP_DECW   = 6'd32
  } op_e;

  localparam logic [7:0] DaaLimit  = 8'h99;
  localparam logic [7:0] DaaAdjHi  = 8'h60;
  localparam logic [7:0] DaaAdjLo  = 8'h06;
  localparam logic [3:0] DaaNibMax = 4'h9;

  typedef struct packed {
    logic [5:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        zero_in;
    logic        subtract_in;
    logic        half_carry_in;
    logic        carry_in;
  } req_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic        writes_result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } rsp_t;

endpackage

/* sv/sm83_alu_if.sv */
interface sm83_alu_req_if import sm83_alu_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sm83_alu_rsp_if import sm83_alu_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/sm83_alu_with_flags_top.sv */
// throughput: one word per cycle while the response is not stalled; input register, flag/result logic, output register
// a stalled response holds the output register while the input register can still fill
// reset: rst_ni asynchronous active low, both stages empty, request ready right after
module sm83_alu_with_flags_top import sm83_alu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sm83_alu_req_if.sink    req_i,
  sm83_alu_rsp_if.source  rsp_o
);

  logic        in_valid_q;
  req_t        in_q;
  logic        out_valid_q;
  rsp_t        out_q;
  rsp_t        out_d;
  logic        out_adv;
  logic        in_adv;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        k;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  r8;
  logic        daa_hi;
  logic        daa_lo;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [8:0]  spc9;

  assign out_adv     = !out_valid_q || rsp_o.ready;
  assign in_adv      = !in_valid_q || out_adv;
  assign req_i.ready = in_adv;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= req_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && req_i.valid) begin
      in_q <= req_i.data;
    end
    if (out_adv && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign a      = in_q.operand_a[7:0];
  assign b      = in_q.operand_b[7:0];
  assign k      = (op_e'(in_q.req_type) == OP_ADC || op_e'(in_q.req_type) == OP_SBC)
                  ? in_q.carry_in : 1'b0;
  assign sum9   = {1'b0, a} + {1'b0, b} + {8'b0, k};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, k};
  assign diff9  = {1'b0, a} - {1'b0, b} - {8'b0, k};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, k};
  assign daa_hi = in_q.carry_in || (a > DaaLimit);
  assign daa_lo = in_q.half_carry_in || (a[3:0] > DaaNibMax);
  assign sum17  = {1'b0, in_q.operand_a} + {1'b0, in_q.operand_b};
  assign hsum13 = {1'b0, in_q.operand_a[11:0]} + {1'b0, in_q.operand_b[11:0]};
  assign spc9   = {1'b0, in_q.operand_a[7:0]} + {1'b0, b};

  always_comb begin
    r8                   = 8'h00;
    out_d.result_value   = '0;
    out_d.writes_result  = 1'b1;
    out_d.zero_out       = in_q.zero_in;
    out_d.subtract_out   = in_q.subtract_in;
    out_d.half_carry_out = in_q.half_carry_in;
    out_d.carry_out      = in_q.carry_in;
    case (op_e'(in_q.req_type))
      OP_ADD, OP_ADC: begin
        r8                   = sum9[7:0];
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = hsum5[4];
        out_d.carry_out      = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8                   = diff9[7:0];
        out_d.subtract_out   = 1'b1;
        out_d.half_carry_out = hdiff5[4];
        out_d.carry_out      = diff9[8];
      end
      OP_AND: begin
        r8                   = a & b;
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = 1'b1;
        out_d.carry_out      = 1'b0;
      end
      OP_XOR, OP_OR: begin
        r8                   = (op_e'(in_q.req_type) == OP_XOR) ? (a ^ b) : (a | b);
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = 1'b0;
        out_d.carry_out      = 1'b0;
      end
      OP_INC8: begin
        r8                   = a + 8'd1;
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = (r8[3:0] == 4'h0);
      end
      OP_DEC8: begin
        r8                   = a - 8'd1;
        out_d.subtract_out   = 1'b1;
        out_d.half_carry_out = (r8[3:0] == 4'hf);
      end
      OP_DAA: begin
        if (in_q.subtract_in) begin
          r8 = a - (in_q.carry_in ? DaaAdjHi : 8'h00)
                 - (in_q.half_carry_in ? DaaAdjLo : 8'h00);
        end else begin
          r8 = a + (daa_hi ? DaaAdjHi : 8'h00) + (daa_lo ? DaaAdjLo : 8'h00);
          out_d.carry_out = daa_hi;
        end
        out_d.half_carry_out = 1'b0;
      end
      OP_CPL: begin
        r8                   = ~a;
        out_d.subtract_out   = 1'b1;
        out_d.half_carry_out = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        out_d.writes_result  = 1'b0;
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = 1'b0;
        out_d.carry_out      = (op_e'(in_q.req_type) == OP_SCF) ? 1'b1 : !in_q.carry_in;
      end
      OP_RLCA, OP_RLC: begin
        r8              = {a[6:0], a[7]};
        out_d.carry_out = a[7];
      end
      OP_RRCA, OP_RRC: begin
        r8              = {a[0], a[7:1]};
        out_d.carry_out = a[0];
      end
      OP_RLA, OP_RL: begin
        r8              = {a[6:0], in_q.carry_in};
        out_d.carry_out = a[7];
      end
      OP_RRA, OP_RR: begin
        r8              = {in_q.carry_in, a[7:1]};
        out_d.carry_out = a[0];
      end
      OP_SLA: begin
        r8              = {a[6:0], 1'b0};
        out_d.carry_out = a[7];
      end
      OP_SRA: begin
        r8              = {a[7], a[7:1]};
        out_d.carry_out = a[0];
      end
      OP_SRL: begin
        r8              = {1'b0, a[7:1]};
        out_d.carry_out = a[0];
      end
      OP_SWAP: begin
        r8              = {a[3:0], a[7:4]};
        out_d.carry_out = 1'b0;
      end
      OP_BIT: begin
        out_d.writes_result  = 1'b0;
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = 1'b1;
      end
      OP_RES: r8 = a & ~(8'd1 << in_q.bit_index);
      OP_SET: r8 = a | (8'd1 << in_q.bit_index);
      OP_ADDW: begin
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = hsum13[12];
        out_d.carry_out      = sum17[16];
      end
      OP_SPE8: begin
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = hsum5[4];
        out_d.carry_out      = spc9[8];
      end
      OP_INCW, OP_DECW: ;
      default: out_d.writes_result = 1'b0;
    endcase

    // result word and zero flag per operation group
    case (op_e'(in_q.req_type))
      OP_CP: begin
        out_d.writes_result = 1'b0;
        out_d.zero_out      = (r8 == 8'h00);
      end
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_INC8, OP_DEC8,
      OP_DAA, OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
        out_d.result_value = {8'h00, r8};
        out_d.zero_out     = (r8 == 8'h00);
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        out_d.result_value   = {8'h00, r8};
        out_d.zero_out       = 1'b0;
      end
      OP_CPL, OP_RES, OP_SET: out_d.result_value = {8'h00, r8};
      OP_BIT: out_d.zero_out = !a[in_q.bit_index];
      OP_ADDW: out_d.result_value = sum17[15:0];
      OP_SPE8: begin
        out_d.result_value = in_q.operand_a + {{8{b[7]}}, b};
        out_d.zero_out     = 1'b0;
      end
      OP_INCW: out_d.result_value = in_q.operand_a + 16'd1;
      OP_DECW: out_d.result_value = in_q.operand_a - 16'd1;
      default: ;
    endcase

    // rotates, shifts and swap clear subtract and half carry; SPE8 clears zero
    case (op_e'(in_q.req_type))
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA, OP_RLC, OP_RRC, OP_RL, OP_RR,
      OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
        out_d.subtract_out   = 1'b0;
        out_d.half_carry_out = 1'b0;
      end
      OP_SPE8: out_d.zero_out = 1'b0;
      default: ;
    endcase
  end

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while both stages are full");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv) |=> out_valid_q)
    else $error("input stage word lost on the way to the output register");

  a_flag_only_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.writes_result) |-> (out_q.result_value == 16'h0000))
    else $error("flag-only word carries a nonzero result");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output register changed");

endmodule
